>>> sv/dtrp_pkg.sv
`timescale 1ns / 1ps
// Package for the delimited trip record parser: character codes, field and
// register indexes, word kinds, queue and result types, stamp weight table.
// No dependencies.
package dtrp_pkg;

    localparam int BYTE_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int KIND_W      = 4;
    localparam int OUT_W       = 24;
    localparam int STAMP_W     = 24;
    localparam int WEIGHT_W    = 20;
    localparam int STATION_W   = 24;
    localparam int BAL_W       = 21;
    localparam int FIELD_IDX_W = 3;
    localparam int POS_W       = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 24;
    localparam int DEF_VALUE_W = 24;

    localparam int DATA_BITS = KIND_W + 6 * OUT_W + BAL_W;
    localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8;
    localparam int PAD_W     = TDATA_W - DATA_BITS;
    localparam int TUSER_W   = 2;

    localparam logic [BYTE_W-1:0] CHAR_SEP  = 8'd59;
    localparam logic [BYTE_W-1:0] CHAR_NL   = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'd48;
    localparam logic [BYTE_W-1:0] CHAR_NINE = 8'd57;

    localparam logic [STATION_W-1:0] RESET_STATION = 24'd901;
    localparam logic [KIND_W-1:0]    RESET_KIND    = 4'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_STATION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND    = 1'b1;

    localparam logic [FIELD_IDX_W-1:0] FLD_KIND          = 3'd0;
    localparam logic [FIELD_IDX_W-1:0] FLD_START_TIME    = 3'd1;
    localparam logic [FIELD_IDX_W-1:0] FLD_START_STATION = 3'd2;
    localparam logic [FIELD_IDX_W-1:0] FLD_START_EXTRA   = 3'd3;
    localparam logic [FIELD_IDX_W-1:0] FLD_END_TIME      = 3'd4;
    localparam logic [FIELD_IDX_W-1:0] FLD_END_STATION   = 3'd5;
    localparam logic [FIELD_IDX_W-1:0] FLD_END_EXTRA     = 3'd6;
    localparam logic [FIELD_IDX_W-1:0] FLD_DROP          = 3'd7;

    localparam logic [POS_W-1:0] POS_MAX = 4'd15;

    localparam logic signed [BAL_W-1:0] BAL_MAX = 21'sh0FFFFF;
    localparam logic signed [BAL_W-1:0] BAL_MIN = 21'sh100000;

    typedef enum logic [2:0] {
        K_OTHER,
        K_DIGIT,
        K_SEP,
        K_NL,
        K_EOI
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [DIGIT_W-1:0] digit;
    } t_item;

    typedef struct packed {
        logic [KIND_W-1:0]       record_kind;
        logic [OUT_W-1:0]        start_seconds;
        logic [OUT_W-1:0]        start_station;
        logic [OUT_W-1:0]        start_extra;
        logic [OUT_W-1:0]        end_seconds;
        logic [OUT_W-1:0]        end_station;
        logic [OUT_W-1:0]        end_extra;
        logic signed [BAL_W-1:0] net_count;
        logic                    departed;
        logic                    arrived;
    } t_result;

    function automatic logic [WEIGHT_W-1:0] stamp_weight(input logic [POS_W-1:0] pos);
        logic [WEIGHT_W-1:0] w;
        case (pos)
            4'd6:    w = 20'd864000;
            4'd7:    w = 20'd86400;
            4'd8:    w = 20'd36000;
            4'd9:    w = 20'd3600;
            4'd10:   w = 20'd600;
            4'd11:   w = 20'd60;
            4'd12:   w = 20'd10;
            4'd13:   w = 20'd1;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

>>> sv/dtrp_front.sv
`timescale 1ns / 1ps
// Front end: classifies each incoming byte and pushes useful words to the queue.
// Depends on dtrp_pkg.
module dtrp_front (
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [dtrp_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_last,
    input  logic                        i_full,
    output logic                        o_push,
    output dtrp_pkg::t_item             o_item
);
    import dtrp_pkg::*;

    t_kind w_kind;

    always_comb begin
        if (i_last) begin
            w_kind = K_EOI;
        end else if (i_byte == CHAR_SEP) begin
            w_kind = K_SEP;
        end else if (i_byte == CHAR_NL) begin
            w_kind = K_NL;
        end else if (i_byte >= CHAR_ZERO && i_byte <= CHAR_NINE) begin
            w_kind = K_DIGIT;
        end else begin
            w_kind = K_OTHER;
        end
    end

    // drop bytes that change nothing
    assign o_ready      = !i_full;
    assign o_push       = i_valid && !i_full && (w_kind != K_OTHER);
    assign o_item.kind  = w_kind;
    assign o_item.digit = DIGIT_W'(i_byte - CHAR_ZERO);

endmodule

>>> sv/dtrp_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of classified words between front and back end.
// Depends on dtrp_pkg.
module dtrp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dtrp_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    output dtrp_pkg::t_item o_item,
    input  logic            i_pop
);
    import dtrp_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_do_pop;

    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_item   = r_mem[r_rd_ptr];
    assign w_do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> sv/dtrp_back.sv
`timescale 1ns / 1ps
// Back end: executes queued words, collects the record fields, keeps the
// station balance and holds one result word. Depends on dtrp_pkg.
module dtrp_back #(
    parameter int VALUE_WIDTH = dtrp_pkg::DEF_VALUE_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [dtrp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dtrp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    input  dtrp_pkg::t_item                 i_item,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output dtrp_pkg::t_result               o_result
);
    import dtrp_pkg::*;

    localparam int VW    = VALUE_WIDTH;
    localparam int CMP_W = (VW > STATION_W) ? VW : STATION_W;

    logic [STATION_W-1:0]    r_station;
    logic [KIND_W-1:0]       r_match_kind;
    logic                    r_header_done, n_header_done;
    logic [FIELD_IDX_W-1:0]  r_field_idx, n_field_idx;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic [KIND_W-1:0]       r_kind, n_kind;
    logic [STAMP_W-1:0]      r_start_sec, n_start_sec;
    logic [STAMP_W-1:0]      r_end_sec, n_end_sec;
    logic [VW-1:0]           r_start_stn, n_start_stn;
    logic [VW-1:0]           r_start_ext, n_start_ext;
    logic [VW-1:0]           r_end_stn, n_end_stn;
    logic [VW-1:0]           r_end_ext, n_end_ext;
    logic signed [BAL_W-1:0] r_balance, n_balance;
    logic                    r_out_valid, n_out_valid;
    t_result                 r_out, n_out;

    logic                    w_slot_free;
    logic [VW-1:0]           w_sel_val;
    logic [VW+3:0]           w_dec;
    logic [VW-1:0]           w_sat;
    logic [STAMP_W-1:0]      w_prod;
    logic [STAMP_W-1:0]      w_sel_sec;
    logic [STAMP_W-1:0]      w_sum_sec;
    logic                    w_kind_ok;
    logic                    w_dep;
    logic                    w_arr;
    logic signed [BAL_W-1:0] w_bal_up;

    assign w_slot_free = !r_out_valid || i_ready;
    assign o_pop       = i_valid && (i_item.kind != K_NL || !r_header_done || w_slot_free);
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        case (r_field_idx)
            FLD_START_STATION: w_sel_val = r_start_stn;
            FLD_START_EXTRA:   w_sel_val = r_start_ext;
            FLD_END_STATION:   w_sel_val = r_end_stn;
            default:           w_sel_val = r_end_ext;
        endcase
    end

    assign w_dec = ({4'b0, w_sel_val} << 3) + ({4'b0, w_sel_val} << 1)
                 + (VW+4)'(i_item.digit);
    assign w_sat = (|w_dec[VW+3:VW]) ? '1 : w_dec[VW-1:0];

    assign w_prod    = {{(STAMP_W-DIGIT_W){1'b0}}, i_item.digit}
                     * {{(STAMP_W-WEIGHT_W){1'b0}}, stamp_weight(r_pos)};
    assign w_sel_sec = (r_field_idx == FLD_START_TIME) ? r_start_sec : r_end_sec;
    assign w_sum_sec = w_sel_sec + w_prod;

    assign w_kind_ok = (r_kind == r_match_kind);
    assign w_dep = w_kind_ok && (CMP_W'(r_start_stn) == CMP_W'(r_station));
    assign w_arr = w_kind_ok && (CMP_W'(r_end_stn) == CMP_W'(r_station));
    assign w_bal_up = (w_dep && r_balance != BAL_MAX) ? r_balance + 1'b1 : r_balance;

    always_comb begin
        n_header_done = r_header_done;
        n_field_idx   = r_field_idx;
        n_pos         = r_pos;
        n_kind        = r_kind;
        n_start_sec   = r_start_sec;
        n_end_sec     = r_end_sec;
        n_start_stn   = r_start_stn;
        n_start_ext   = r_start_ext;
        n_end_stn     = r_end_stn;
        n_end_ext     = r_end_ext;
        n_balance     = r_balance;
        n_out_valid   = r_out_valid && !i_ready;
        n_out         = r_out;

        if (o_pop) begin
            unique case (i_item.kind)
                K_EOI: begin
                    n_header_done = 1'b0;
                    n_field_idx   = '0;
                    n_pos         = '0;
                    n_kind        = '0;
                    n_start_sec   = '0;
                    n_end_sec     = '0;
                    n_start_stn   = '0;
                    n_start_ext   = '0;
                    n_end_stn     = '0;
                    n_end_ext     = '0;
                end
                K_NL: begin
                    if (!r_header_done) begin
                        n_header_done = 1'b1;
                    end else begin
                        n_balance = (w_arr && w_bal_up != BAL_MIN)
                                  ? w_bal_up - 1'b1 : w_bal_up;
                        n_out_valid           = 1'b1;
                        n_out.record_kind     = r_kind;
                        n_out.start_seconds   = OUT_W'(r_start_sec);
                        n_out.start_station   = OUT_W'(r_start_stn);
                        n_out.start_extra     = OUT_W'(r_start_ext);
                        n_out.end_seconds     = OUT_W'(r_end_sec);
                        n_out.end_station     = OUT_W'(r_end_stn);
                        n_out.end_extra       = OUT_W'(r_end_ext);
                        n_out.net_count       = n_balance;
                        n_out.departed        = w_dep;
                        n_out.arrived         = w_arr;
                        n_field_idx = '0;
                        n_pos       = '0;
                        n_kind      = '0;
                        n_start_sec = '0;
                        n_end_sec   = '0;
                        n_start_stn = '0;
                        n_start_ext = '0;
                        n_end_stn   = '0;
                        n_end_ext   = '0;
                    end
                end
                K_SEP: begin
                    if (r_header_done) begin
                        if (r_field_idx != FLD_DROP) begin
                            n_field_idx = r_field_idx + 1'b1;
                        end
                        n_pos = '0;
                    end
                end
                K_DIGIT: begin
                    if (r_header_done) begin
                        if (r_pos != POS_MAX) begin
                            n_pos = r_pos + 1'b1;
                        end
                        unique case (r_field_idx)
                            FLD_KIND:          n_kind      = i_item.digit;
                            FLD_START_TIME:    n_start_sec = w_sum_sec;
                            FLD_END_TIME:      n_end_sec   = w_sum_sec;
                            FLD_START_STATION: n_start_stn = w_sat;
                            FLD_START_EXTRA:   n_start_ext = w_sat;
                            FLD_END_STATION:   n_end_stn   = w_sat;
                            FLD_END_EXTRA:     n_end_ext   = w_sat;
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station     <= RESET_STATION;
            r_match_kind  <= RESET_KIND;
            r_header_done <= 1'b0;
            r_field_idx   <= '0;
            r_pos         <= '0;
            r_kind        <= '0;
            r_start_sec   <= '0;
            r_end_sec     <= '0;
            r_start_stn   <= '0;
            r_start_ext   <= '0;
            r_end_stn     <= '0;
            r_end_ext     <= '0;
            r_balance     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_STATION: r_station    <= i_cfg_data;
                    CFG_KIND:    r_match_kind <= i_cfg_data[KIND_W-1:0];
                    default: ;
                endcase
            end
            r_header_done <= n_header_done;
            r_field_idx   <= n_field_idx;
            r_pos         <= n_pos;
            r_kind        <= n_kind;
            r_start_sec   <= n_start_sec;
            r_end_sec     <= n_end_sec;
            r_start_stn   <= n_start_stn;
            r_start_ext   <= n_start_ext;
            r_end_stn     <= n_end_stn;
            r_end_ext     <= n_end_ext;
            r_balance     <= n_balance;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

>>> sv/delimited_trip_record_parser_top.sv
`timescale 1ns / 1ps
// Top level of the delimited trip record parser: front end, word queue, back end.
// Depends on dtrp_pkg, dtrp_front, dtrp_queue, dtrp_back.
//
// Takes one character per cycle on the slave stream; tlast marks end of stream,
// which drops any partial line and skips the next line as a header again. Each
// newline after the header gives one record word on the master stream, registered
// as the newline leaves the two-word queue. Input is stalled only when
// a record word is still held unread in the output register and the queue has
// filled behind it. Configuration writes are always accepted; write them only
// while the stream is idle. The station balance survives end of stream.
module delimited_trip_record_parser_top #(
    parameter int VALUE_WIDTH = dtrp_pkg::DEF_VALUE_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dtrp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dtrp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // byte_in
    input  logic [dtrp_pkg::BYTE_W-1:0]     s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // record_kind, start_seconds, start_station, start_extra, end_seconds,
    // end_station, end_extra, net_count, zero pad
    output logic [dtrp_pkg::TDATA_W-1:0]    m_axis_tdata,
    // departed, arrived
    output logic [dtrp_pkg::TUSER_W-1:0]    m_axis_tuser
);
    import dtrp_pkg::*;

    logic    w_push;
    logic    w_full;
    logic    w_q_valid;
    logic    w_pop;
    t_item   w_in_item;
    t_item   w_q_item;
    t_result w_result;

    assign o_cfg_ready = 1'b1;

    dtrp_front u_front (
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_item  (w_in_item)
    );

    dtrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    dtrp_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (w_q_valid),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (w_result)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}},
                           w_result.net_count,
                           w_result.end_extra,
                           w_result.end_station,
                           w_result.end_seconds,
                           w_result.start_extra,
                           w_result.start_station,
                           w_result.start_seconds,
                           w_result.record_kind};
    assign m_axis_tuser = {w_result.arrived, w_result.departed};

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Testbench for delimited_trip_record_parser_top: streams trip records byte by byte
// under several register settings and checks every record word against a predictor.
// Depends on dtrp_pkg and the parser RTL.
module tb;
    import dtrp_pkg::*;

    localparam int VW          = DEF_VALUE_W;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 12;
    localparam int NET_LO      = KIND_W + 6 * OUT_W;
    localparam int PHASE_BYTES = 160;
    localparam int PHASE_RECS  = 4;

    class record_ledger;
        logic [STATION_W-1:0] watched;
        logic [KIND_W-1:0]    kind_sel;
        bit                   header_seen;
        int                   fld;
        int                   pos;
        longint unsigned      vals[7];
        int                   balance;
        t_result              records_due[$];
        int                   mismatches;
        int                   records_made;

        function new();
            watched      = RESET_STATION;
            kind_sel     = RESET_KIND;
            header_seen  = 1'b0;
            balance      = 0;
            mismatches   = 0;
            records_made = 0;
            clear_line();
        endfunction

        function void clear_line();
            fld = 0;
            pos = 0;
            foreach (vals[k]) vals[k] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_STATION) begin
                watched = data[STATION_W-1:0];
            end else if (idx == CFG_KIND) begin
                kind_sel = data[KIND_W-1:0];
            end
        endfunction

        function longint unsigned seconds_weight(int p);
            case (p)
                6:       return 864000;
                7:       return 86400;
                8:       return 36000;
                9:       return 3600;
                10:      return 600;
                11:      return 60;
                12:      return 10;
                13:      return 1;
                default: return 0;
            endcase
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b, logic eoi);
            longint unsigned vmax;
            longint unsigned v;
            longint unsigned digit;
            t_result         r;
            bit              dep;
            bit              arr;
            vmax = (64'd1 << VW) - 1;
            if (eoi) begin
                clear_line();
                header_seen = 1'b0;
                return;
            end
            if (!header_seen) begin
                if (b == CHAR_NL) header_seen = 1'b1;
                return;
            end
            if (b == CHAR_SEP) begin
                if (fld < FLD_DROP) fld++;
                pos = 0;
                return;
            end
            if (b != CHAR_NL) begin
                if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                    digit = b - CHAR_ZERO;
                    case (fld)
                        FLD_KIND: vals[fld] = digit;
                        FLD_START_TIME, FLD_END_TIME:
                            vals[fld] += digit * seconds_weight(pos);
                        FLD_START_STATION, FLD_START_EXTRA, FLD_END_STATION, FLD_END_EXTRA: begin
                            v = vals[fld] * 10 + digit;
                            vals[fld] = (v > vmax) ? vmax : v;
                        end
                        default: ;
                    endcase
                    if (pos < POS_MAX) pos++;
                end
                return;
            end
            dep = (vals[FLD_KIND] == kind_sel) && (vals[FLD_START_STATION] == watched);
            arr = (vals[FLD_KIND] == kind_sel) && (vals[FLD_END_STATION] == watched);
            if (dep && balance < int'(BAL_MAX)) balance++;
            if (arr && balance > int'(BAL_MIN)) balance--;
            r.record_kind   = vals[FLD_KIND][KIND_W-1:0];
            r.start_seconds = vals[FLD_START_TIME][OUT_W-1:0];
            r.start_station = vals[FLD_START_STATION][OUT_W-1:0];
            r.start_extra   = vals[FLD_START_EXTRA][OUT_W-1:0];
            r.end_seconds   = vals[FLD_END_TIME][OUT_W-1:0];
            r.end_station   = vals[FLD_END_STATION][OUT_W-1:0];
            r.end_extra     = vals[FLD_END_EXTRA][OUT_W-1:0];
            r.net_count     = balance[BAL_W-1:0];
            r.departed      = dep;
            r.arrived       = arr;
            records_due.push_back(r);
            records_made++;
            clear_line();
        endfunction

        function void flag(string msg);
            if (mismatches < 10) $display("%0t: %s", $time, msg);
            mismatches++;
        endfunction

        function void compare(string name, longint unsigned want, longint unsigned got);
            if (want != got)
                flag($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got));
        endfunction

        function void check_word(logic [TDATA_W-1:0] d, logic [TUSER_W-1:0] u);
            t_result         want;
            logic [OUT_W-1:0] wv[6];
            string           names[6];
            if (records_due.size() == 0) begin
                flag($sformatf("unexpected record word 0x%0h", d));
                return;
            end
            want = records_due.pop_front();
            wv = '{want.start_seconds, want.start_station, want.start_extra,
                   want.end_seconds, want.end_station, want.end_extra};
            names = '{"start_seconds", "start_station", "start_extra",
                      "end_seconds", "end_station", "end_extra"};
            compare("record_kind", want.record_kind, d[KIND_W-1:0]);
            for (int k = 0; k < 6; k++)
                compare(names[k], wv[k], d[KIND_W + k * OUT_W +: OUT_W]);
            compare("net_count", {want.net_count}, d[NET_LO +: BAL_W]);
            compare("departed", want.departed, u[0]);
            compare("arrived", want.arrived, u[1]);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic [TUSER_W-1:0]    m_axis_tuser;

    record_ledger         ledger = new();
    bit                   idling_on = 1'b1;
    bit                   gaps_on = 1'b1;
    int                   hold_left = 0;
    int                   quiet_cycles = 0;
    int                   bytes_sent = 0;
    logic [STATION_W-1:0] cur_station = RESET_STATION;
    logic [KIND_W-1:0]    cur_kind = RESET_KIND;

    delimited_trip_record_parser_top #(.VALUE_WIDTH(VW)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) ledger.write_reg(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) ledger.note_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) ledger.check_word(m_axis_tdata, m_axis_tuser);
        end
    end

    // hold the output back in random bursts while idling_on is set
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            hold_left = $urandom_range(0, 12);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic put_byte(input logic [BYTE_W-1:0] b, input logic eoi);
        if (idling_on && gaps_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eoi;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) put_byte(s[k], 1'b0);
    endtask

    function automatic logic [BYTE_W-1:0] junk_byte();
        logic [BYTE_W-1:0] c;
        do c = BYTE_W'($urandom_range(0, 255));
        while (c == CHAR_NL || c == CHAR_SEP || (c >= CHAR_ZERO && c <= CHAR_NINE));
        return c;
    endfunction

    // field text with the odd stray non-digit mixed in
    task automatic put_field(input string s);
        for (int k = 0; k < s.len(); k++) begin
            if ($urandom_range(0, 11) == 0) put_byte(junk_byte(), 1'b0);
            put_byte(s[k], 1'b0);
        end
    endtask

    function automatic string digit_text(input int n);
        string s = "";
        for (int k = 0; k < n; k++) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        return s;
    endfunction

    function automatic string field_text(input int k);
        logic [STATION_W-1:0] rnd;
        rnd = STATION_W'($urandom);
        case (k)
            FLD_KIND:
                case ($urandom_range(0, 7))
                    0:       return "";
                    1:       return digit_text($urandom_range(2, 3));
                    2, 3:    return $sformatf("%0d", $urandom_range(0, 9));
                    default: return $sformatf("%0d", cur_kind);
                endcase
            FLD_START_TIME, FLD_END_TIME:
                case ($urandom_range(0, 4))
                    0, 1:    return "";
                    2:       return digit_text($urandom_range(1, 18));
                    default: return digit_text(14);
                endcase
            FLD_START_STATION, FLD_END_STATION:
                case ($urandom_range(0, 5))
                    0:       return "";
                    1, 2:    return $sformatf("%0d", cur_station);
                    3:       return $sformatf("%0d", $urandom_range(0, 999));
                    4:       return $sformatf("%0d", rnd);
                    default: return digit_text($urandom_range(8, 11));
                endcase
            default:
                case ($urandom_range(0, 2))
                    0:       return "";
                    1:       return $sformatf("%0d", $urandom_range(0, 99));
                    default: return digit_text($urandom_range(1, 12));
                endcase
        endcase
    endfunction

    task automatic send_record();
        int last_fld;
        gaps_on  = ($urandom_range(0, 3) != 0);
        last_fld = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : int'(FLD_END_EXTRA);
        for (int k = 0; k <= last_fld; k++) begin
            if (k > 0) put_byte(CHAR_SEP, 1'b0);
            put_field(field_text(k));
        end
        if ($urandom_range(0, 9) == 0) begin
            put_byte(CHAR_SEP, 1'b0);
            put_field(digit_text($urandom_range(0, 4)));
            put_byte(CHAR_SEP, 1'b0);
            put_field(digit_text(2));
        end
        if ($urandom_range(0, 14) == 0) put_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 24) == 0) begin
            put_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
            put_text("trip;2;3\n");
        end else begin
            put_byte(CHAR_NL, 1'b0);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (ledger.records_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        logic [STATION_W-1:0] stations[4];
        logic [KIND_W-1:0]    kinds[4];
        int                   base_bytes;
        int                   base_recs;
        stations = '{RESET_STATION, 24'd0, 24'hFFFFFF, 24'($urandom)};
        kinds    = '{RESET_KIND, 4'd0, 4'd9, 4'($urandom_range(0, 9))};
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_STATION;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        put_text("trip;9;901\n");
        put_text("1;;901;;;901\n");
        put_text("0;00000000000000;0;0;99999999999999;99999999;99999999\n");
        put_text("17x;9999999999999999;12a3;;;;;;8;;\n");
        put_text("5;12");
        put_byte(8'hFF, 1'b1);
        put_text("hdr\n1;;901;;;5\n");

        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) begin
                settle();
                cur_station = stations[ph];
                cur_kind    = kinds[ph];
                write_reg(CFG_STATION, cur_station);
                write_reg(CFG_KIND, CFG_DATA_W'(cur_kind));
                i_cfg_valid <= 1'b0;
            end
            if (ph == 3) idling_on = 1'b0;
            base_bytes = bytes_sent;
            base_recs  = ledger.records_made;
            while (bytes_sent - base_bytes < PHASE_BYTES
                    || ledger.records_made - base_recs < PHASE_RECS)
                send_record();
        end
        settle();

        if (ledger.records_due.size() != 0)
            $display("%0d record words never arrived", ledger.records_due.size());
        if (ledger.mismatches == 0 && ledger.records_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
